/* rtl/grouped_categorical_sampler_assert.svh */
// ----------------------------------------------------------------------------
// Grouped categorical sampler assertion macros
// Shared concurrent assertion forms; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GROUPED_CATEGORICAL_SAMPLER_ASSERT_SVH
`define GROUPED_CATEGORICAL_SAMPLER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define GCS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define GCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GCS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define GCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* rtl/gcs_pkg.sv */
// ----------------------------------------------------------------------------
// Grouped categorical sampler package
// Field widths, action codes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package gcs_pkg;

	localparam int GROUP_W    = 6;
	localparam int CAT_FLD_W  = 5;
	localparam int WEIGHT_W   = 16;
	localparam int UNIF_W     = 16;
	localparam int SUM_W      = 21;
	localparam int TARGET_W   = SUM_W + UNIF_W;
	localparam int OUT_W      = 6;
	localparam int NCAT_W     = 6;

	localparam int MAX_GROUPS_DEF = 64;
	localparam int MAX_CATS_DEF   = 32;

	localparam logic [NCAT_W-1:0] NCAT_RST = NCAT_W'(32);
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef logic [GROUP_W-1:0]   group_t;
	typedef logic [CAT_FLD_W-1:0] cat_fld_t;
	typedef logic [WEIGHT_W-1:0]  weight_t;
	typedef logic [UNIF_W-1:0]    unif_t;
	typedef logic [OUT_W-1:0]     out_cat_t;
	typedef logic [NCAT_W-1:0]    ncat_t;

	typedef struct packed {
		logic load;      // write one weight
		logic start;     // latch sample, read group total
		logic prep;      // form target, read first cumulative entry
		logic ans_one;   // group out of range: answer 1
		logic scan_adv;  // step to next category
		logic ans_k;     // scan stops at current category
		logic out_load;  // move answer into output register
	} cmd_t;

	typedef struct packed {
		logic grp_ok;
		logic hit;
		logic last;
		logic out_free;
	} sts_t;

endpackage

/* rtl/gcs_if.sv */
// ----------------------------------------------------------------------------
// Grouped categorical sampler channels
// Valid/ready channels for input items and sampled results.
// ----------------------------------------------------------------------------
interface gcs_item_if;
	import gcs_pkg::*;

	logic     valid;
	logic     ready;
	logic     action;
	group_t   group;
	cat_fld_t category;
	weight_t  weight;
	unif_t    uniform;

	modport source (output valid, action, group, category, weight, uniform, input ready);
	modport sink   (input valid, action, group, category, weight, uniform, output ready);
endinterface

interface gcs_result_if;
	import gcs_pkg::*;

	logic     valid;
	logic     ready;
	out_cat_t sampled_category;

	modport source (output valid, sampled_category, input ready);
	modport sink   (input valid, sampled_category, output ready);
endinterface

/* rtl/gcs_ctrl.sv */
// ----------------------------------------------------------------------------
// Grouped categorical sampler controller
// Sequences load, total lookup, category scan and result hand-off.
// ----------------------------------------------------------------------------
`include "grouped_categorical_sampler_assert.svh"

module gcs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          item_action,
	output logic          item_ready,
	input  gcs_pkg::sts_t sts,
	output gcs_pkg::cmd_t cmd
);
	import gcs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_TOT  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       acc;
	logic       stop;

	assign item_ready = (state_q == S_IDLE);
	assign acc        = item_valid && item_ready;
	assign stop       = sts.hit || sts.last;

	always_comb begin
		cmd          = '0;
		cmd.load     = acc && (item_action == ACT_LOAD);
		cmd.start    = acc && (item_action == ACT_SAMPLE);
		cmd.prep     = (state_q == S_TOT) && sts.grp_ok;
		cmd.ans_one  = (state_q == S_TOT) && !sts.grp_ok;
		cmd.scan_adv = (state_q == S_SCAN) && !stop;
		cmd.ans_k    = (state_q == S_SCAN) && stop;
		cmd.out_load = (state_q == S_OUT) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.start) state_d = S_TOT;
			end
			S_TOT: begin
				state_d = sts.grp_ok ? S_SCAN : S_OUT;
			end
			S_SCAN: begin
				if (stop) state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`GCS_ASSERT_NEXT(a_start_to_total, clk, arst_n, cmd.start, state_q == S_TOT, "sample did not enter total lookup")
	`GCS_ASSERT_NOW(a_one_command, clk, arst_n, 1'b1, $onehot0(cmd), "more than one datapath command at once")

endmodule

/* rtl/gcs_dpath.sv */
// ----------------------------------------------------------------------------
// Grouped categorical sampler datapath
// Cumulative and total memories, running sum, target multiply, scan compare.
// ----------------------------------------------------------------------------
`include "grouped_categorical_sampler_assert.svh"

module gcs_dpath #(
	parameter int MAX_GROUPS = gcs_pkg::MAX_GROUPS_DEF,
	parameter int MAX_CATS   = gcs_pkg::MAX_CATS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  gcs_pkg::ncat_t   cfg_wdata,
	input  gcs_pkg::group_t  group,
	input  gcs_pkg::cat_fld_t category,
	input  gcs_pkg::weight_t weight,
	input  gcs_pkg::unif_t   uniform,
	input  gcs_pkg::cmd_t    cmd,
	output gcs_pkg::sts_t    sts,
	input  logic             res_ready,
	output logic             res_valid,
	output gcs_pkg::out_cat_t res_cat
);
	import gcs_pkg::*;

	localparam int GIDX_W    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int CAT_W     = $clog2(MAX_CATS);
	localparam int CNT_W     = $clog2(MAX_CATS + 1);
	localparam int CUM_DEPTH = MAX_GROUPS * MAX_CATS;
	localparam int AW        = $clog2(CUM_DEPTH);

	logic [SUM_W-1:0]    cum_mem [CUM_DEPTH];
	logic [SUM_W-1:0]    tot_mem [MAX_GROUPS];

	ncat_t               ncat_q;
	logic [SUM_W-1:0]    rsum_q;
	logic [GIDX_W-1:0]   gidx_q;
	logic                grp_ok_q;
	unif_t               unif_q;
	logic [SUM_W-1:0]    tot_rd_q;
	logic [SUM_W-1:0]    cum_rd_q;
	logic [TARGET_W-1:0] target_q;
	logic [CAT_W-1:0]    k_q;
	out_cat_t            ans_q;
	logic                res_valid_q;
	out_cat_t            res_cat_q;

	logic [GIDX_W-1:0]   in_gidx;
	logic                ld_ok;
	logic [SUM_W:0]      sum_ext;
	logic [SUM_W-1:0]    sum;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;
	logic [CAT_W-1:0]    k_rd;
	logic [CNT_W-1:0]    n_act;
	logic [TARGET_W-1:0] prod;

	assign in_gidx = GIDX_W'(group);
	assign ld_ok   = (32'(group) < 32'(MAX_GROUPS)) && (32'(category) < 32'(MAX_CATS));

	// saturating running sum; category 0 restarts it
	assign sum_ext = {1'b0, rsum_q} + (SUM_W + 1)'(weight);
	always_comb begin
		if (category == '0) begin
			sum = SUM_W'(weight);
		end else if (sum_ext[SUM_W]) begin
			sum = SUM_MAX;
		end else begin
			sum = sum_ext[SUM_W-1:0];
		end
	end

	assign wr_addr = AW'(32'(in_gidx) * 32'(MAX_CATS) + 32'(category));
	assign k_rd    = cmd.prep ? '0 : CAT_W'(k_q + 1'b1);
	assign rd_addr = AW'(32'(gidx_q) * 32'(MAX_CATS) + 32'(k_rd));

	// clamp category count to 1..MAX_CATS
	always_comb begin
		if (ncat_q == '0) begin
			n_act = CNT_W'(1);
		end else if (32'(ncat_q) > 32'(MAX_CATS)) begin
			n_act = CNT_W'(MAX_CATS);
		end else begin
			n_act = CNT_W'(ncat_q);
		end
	end

	assign prod = unif_q * tot_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.load && ld_ok) begin
			cum_mem[wr_addr] <= sum;
			tot_mem[in_gidx] <= sum;
		end
		if (cmd.start) begin
			tot_rd_q <= tot_mem[in_gidx];
		end
		if (cmd.prep || cmd.scan_adv) begin
			cum_rd_q <= cum_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			gidx_q   <= in_gidx;
			grp_ok_q <= (32'(group) < 32'(MAX_GROUPS));
			unif_q   <= uniform;
		end
		if (cmd.prep) begin
			target_q <= prod;
		end
		if (cmd.prep || cmd.scan_adv) begin
			k_q <= k_rd;
		end
		if (cmd.ans_one) begin
			ans_q <= OUT_W'(1);
		end else if (cmd.ans_k) begin
			ans_q <= OUT_W'(32'(k_q) + 32'd1);
		end
		if (cmd.out_load) begin
			res_cat_q <= ans_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncat_q      <= NCAT_RST;
			rsum_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) ncat_q <= cfg_wdata;
			if (cmd.load && ld_ok) rsum_q <= sum;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign sts.grp_ok   = grp_ok_q;
	assign sts.hit      = ({cum_rd_q, {UNIF_W{1'b0}}} >= target_q);
	assign sts.last     = ((CNT_W'(k_q) + CNT_W'(1)) == n_act);
	assign sts.out_free = !res_valid_q || res_ready;

	assign res_valid = res_valid_q;
	assign res_cat   = res_cat_q;

	`GCS_ASSERT_NOW(a_no_overrun, clk, arst_n, cmd.scan_adv, (CNT_W'(k_q) + CNT_W'(1)) < n_act, "scan advanced past last category")
	`GCS_ASSERT_NOW(a_out_free, clk, arst_n, cmd.out_load, !res_valid_q || res_ready, "result overwritten before transfer")

endmodule

/* rtl/grouped_categorical_sampler.sv */
// ----------------------------------------------------------------------------
// Grouped categorical sampler
// Inverse-CDF draw of a one-based category from per-group cumulative weights.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: a transfer with action load writes one weight for
//   (group, category); category 0 restarts the running sum, later categories
//   add to it (saturating at 21 bits). Loads give no result.
//   A transfer with action sample gives exactly one result on the result
//   channel: the first category k (1..num_categories) whose cumulative sum,
//   shifted up 16 bits, reaches uniform * group total.
//   cfg_we/cfg_wdata write num_categories; write it only while idle.
//   A sample holds the block while it reads the group total, scans the
//   categories in order up to the one found and waits to move the answer
//   into the output register; one cumulative entry is read from the
//   synchronous table memory per scan cycle. An out-of-range group skips
//   the scan and answers 1.
//   A finished result waits in the output register; the next item is taken
//   meanwhile, and a later sample holds its answer until the register frees.
//   Reset clears the running sum, sets num_categories to 32 and drops any
//   pending result; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module grouped_categorical_sampler #(
	parameter int MAX_GROUPS = gcs_pkg::MAX_GROUPS_DEF,
	parameter int MAX_CATS   = gcs_pkg::MAX_CATS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  gcs_pkg::ncat_t  cfg_wdata,
	gcs_item_if.sink        item,
	gcs_result_if.source    result
);
	import gcs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// controller: handshake and sequencing only
	gcs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_action (item.action),
		.item_ready  (item.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	// datapath: memories, arithmetic and the output register
	gcs_dpath #(
		.MAX_GROUPS (MAX_GROUPS),
		.MAX_CATS   (MAX_CATS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.group     (item.group),
		.category  (item.category),
		.weight    (item.weight),
		.uniform   (item.uniform),
		.cmd       (cmd),
		.sts       (sts),
		.res_ready (result.ready),
		.res_valid (result.valid),
		.res_cat   (result.sampled_category)
	);

endmodule
